>>> design/rcps_pkg.sv
// rcps_pkg: shared types, constants and elaboration-time tables for the pulse shaper
// used by rcps_front, rcps_queue, rcps_back and rc_channel_pulse_shaper_core
// no dependencies
package rcps_pkg;

  localparam int NUM_CHANNELS   = 8;
  localparam int EXP_TABLE_BITS = 10;
  localparam int FRAC_SIZE      = 1 << EXP_TABLE_BITS;

  localparam int CH_W   = 3;
  localparam int IDX_W  = 3;
  localparam int SET_W  = 16;
  localparam int CV_W   = 10;
  localparam int PW_W   = 12;
  localparam int CFG_W  = 4;
  localparam int NSET   = 8;

  localparam int BANK_DEPTH = (NUM_CHANNELS < 8) ? NUM_CHANNELS : 8;
  localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  typedef enum logic {
    OP_PULSE = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  typedef enum logic {
    CFG_THROTTLE = 1'b0,
    CFG_ENDPOINT = 1'b1
  } cfg_idx_t;

  typedef enum logic [IDX_W-1:0] {
    SET_EXPO = 3'd0,
    SET_DUAL = 3'd1,
    SET_SUB  = 3'd2,
    SET_EPL  = 3'd3,
    SET_EPH  = 3'd4,
    SET_PWL  = 3'd5,
    SET_PWH  = 3'd6,
    SET_REV  = 3'd7
  } set_idx_t;

  // expo: t = round(e*(1023-n)*2^EB / 10230)
  localparam int EXP_DIV   = 10230;
  localparam int EXP_HALF  = 5115;
  localparam int X_W       = 18;
  localparam int Y_W       = X_W + EXP_TABLE_BITS;
  localparam int M_EXP_W   = Y_W - 13;
  localparam logic [M_EXP_W-1:0] M_EXP = M_EXP_W'((64'd1 << Y_W) / EXP_DIV);
  localparam int TQ_W      = M_EXP_W;
  localparam int TI_W      = TQ_W - EXP_TABLE_BITS;
  localparam int P1_W      = Y_W + M_EXP_W;

  // reciprocals for the constant dividers
  localparam int A_W = 27;
  localparam logic [17:0] M_D1023 = 18'((64'd1 << A_W) / 1023);
  localparam int Q_W = 18;
  localparam logic [11:0] M_D100  = 12'((64'd1 << Q_W) / 100);
  localparam int N_W = 18;
  localparam logic [9:0]  M_D511  = 10'((64'd1 << N_W) / 511);
  localparam int R_W = 26;
  localparam logic [16:0] M_R1023 = 17'((64'd1 << R_W) / 1023);

  typedef logic [16:0] gain_t;
  typedef gain_t frac_tab_t [FRAC_SIZE];
  typedef gain_t int_tab_t [12];
  typedef logic [8:0] lo_t;
  typedef logic [9:0] pos_t;
  typedef lo_t lo_tab_t [101];
  typedef pos_t pos_tab_t [101];

  localparam int_tab_t EXP_INT = '{
    17'd65536, 17'd24109, 17'd8869, 17'd3263, 17'd1200, 17'd442,
    17'd162, 17'd60, 17'd22, 17'd8, 17'd3, 17'd1
  };

  typedef struct packed {
    logic               ok;
    logic               thr;
    logic               bil;
    logic               neg;
    logic [CV_W-1:0]    v;
    logic [CV_W-1:0]    n;
    logic [7:0]         e;
    logic [6:0]         d;
    logic signed [15:0] trim;
    lo_t                lo;
    pos_t               hi;
    logic [15:0]        low;
    logic [15:0]        high;
  } ctx_t;

  // long division for elaboration-time tables
  function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], a[i]};
      if (r >= {1'b0, b}) begin
        r    = r - {1'b0, b};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic frac_tab_t build_frac_tab();
    frac_tab_t   tab;
    logic [63:0] f;
    logic [63:0] term;
    logic [63:0] sum;
    for (int i = 0; i < FRAC_SIZE; i++) begin
      f    = 64'(i) << (32 - EXP_TABLE_BITS);
      term = 64'd1 << 32;
      sum  = term;
      for (int k = 1; k < 40; k++) begin
        if (term != 64'd0) begin
          term = udiv64((term * f) >> 32, 64'(k));
          sum  = sum + term;
        end
      end
      tab[i] = 17'(udiv64((64'd1 << 48) + (sum >> 1), sum));
    end
    return tab;
  endfunction

  function automatic lo_tab_t build_lo_tab();
    lo_tab_t tab;
    for (int i = 0; i <= 100; i++) begin
      tab[i] = 9'((511 * (100 - i)) / 100);
    end
    return tab;
  endfunction

  function automatic pos_tab_t build_hi_tab(input logic bil);
    pos_tab_t tab;
    int       hv;
    for (int i = 0; i <= 100; i++) begin
      hv = bil ? 512 + (512 * i) / 100 : 511 + (512 * i) / 100;
      if (hv == 1024) begin
        hv = 1023;
      end
      tab[i] = 10'(hv);
    end
    return tab;
  endfunction

  function automatic logic [6:0] sat100(input logic [15:0] x);
    return (x > 16'd100) ? 7'd100 : x[6:0];
  endfunction

endpackage

>>> design/rcps_queue.sv
// rcps_queue: two-entry queue of classified items between front and back
// depends on rcps_pkg
module rcps_queue
  import rcps_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  ctx_t push_ctx,
  output logic full,
  output logic pop,
  output ctx_t pop_ctx
);

  ctx_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign pop     = (count != 2'd0);
  assign pop_ctx = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_ctx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push && !full) - 2'(pop);
    end
  end

endmodule

>>> design/rcps_front.sv
// rcps_front: accepts words, holds the per-channel setting banks, classifies pulse items
// depends on rcps_pkg
module rcps_front
  import rcps_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic                    op,
  input  logic [CH_W-1:0]         channel,
  input  logic [CV_W-1:0]         control_value,
  input  logic                    throttle_cut,
  input  logic [IDX_W-1:0]        setting_index,
  input  logic signed [SET_W-1:0] setting_value,
  input  logic [CFG_W-1:0]        throttle_channel,
  input  logic                    endpoint_mode,
  input  logic                    q_full,
  output logic                    push,
  output ctx_t                    push_ctx
);

  localparam lo_tab_t  LO_TAB = build_lo_tab();
  localparam pos_tab_t HL_TAB = build_hi_tab(1'b0);
  localparam pos_tab_t HB_TAB = build_hi_tab(1'b1);

  logic [SET_W-1:0] bank [NSET][BANK_DEPTH];

  logic             accept;
  logic             in_ok;
  logic             f0_valid;
  logic [CH_W-1:0]  f0_ch;
  logic             f0_ok;
  logic [CV_W-1:0]  f0_cv;
  logic             f0_cut;
  logic [SET_W-1:0] f0_set [NSET];

  logic             thr;
  logic [CV_W-1:0]  v;
  logic [10:0]      v2;
  logic             neg;
  logic [CV_W-1:0]  mag;
  logic [6:0]       epl;
  logic [6:0]       eph;

  assign busy   = f0_valid && q_full;
  assign accept = start && !busy;
  assign in_ok  = (int'(channel) < NUM_CHANNELS);
  assign push   = f0_valid && !q_full;

  always_ff @(posedge clk) begin
    if (accept && (op == OP_WRITE) && in_ok) begin
      bank[setting_index][channel[BANK_AW-1:0]] <= setting_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f0_valid <= 1'b0;
    end else if (!busy) begin
      f0_valid <= accept && (op == OP_PULSE);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f0_ch  <= channel;
      f0_ok  <= in_ok;
      f0_cv  <= control_value;
      f0_cut <= throttle_cut;
      for (int k = 0; k < NSET; k++) begin
        f0_set[k] <= bank[k][channel[BANK_AW-1:0]];
      end
    end
  end

  always_comb begin
    thr = (throttle_channel != '0) &&
          ({1'b0, f0_ch} == (throttle_channel - CFG_W'(1)));
    v   = (f0_cut && thr) ? '0 : f0_cv;
    v2  = {v, 1'b0};
    neg = ~v[CV_W-1];
    mag = neg ? 10'(11'd1023 - v2) : 10'(v2 - 11'd1023);
    epl = sat100(f0_set[SET_EPL]);
    eph = sat100(f0_set[SET_EPH]);

    push_ctx.ok   = f0_ok;
    push_ctx.thr  = thr;
    push_ctx.bil  = endpoint_mode;
    push_ctx.neg  = neg;
    push_ctx.v    = v;
    push_ctx.n    = thr ? v : mag;
    push_ctx.e    = f0_set[SET_EXPO][7:0];
    push_ctx.d    = sat100(f0_set[SET_DUAL]);
    push_ctx.trim = $signed(f0_set[SET_SUB]);
    push_ctx.lo   = LO_TAB[epl];
    push_ctx.hi   = endpoint_mode ? HB_TAB[eph] : HL_TAB[eph];
    push_ctx.low  = (f0_set[SET_REV] != '0) ? f0_set[SET_PWH] : f0_set[SET_PWL];
    push_ctx.high = (f0_set[SET_REV] != '0) ? f0_set[SET_PWL] : f0_set[SET_PWH];
  end

endmodule

>>> design/rcps_back.sv
// rcps_back: thirteen-stage pipeline for expo, dual rate, trim, endpoints and pulse map
// depends on rcps_pkg
module rcps_back
  import rcps_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  ctx_t            in_ctx,
  output logic            done,
  output logic [PW_W-1:0] pulse_width
);

  localparam int NSTG = 13;
  localparam frac_tab_t FRAC_ROM = build_frac_tab();

  logic [NSTG-1:0] vld;
  ctx_t            c [NSTG];

  logic [X_W-1:0]   s1_x;
  logic [A_W-1:0]   s1_amag;
  logic             s1_aneg;
  logic [16:0]      coef;

  logic [Y_W-1:0]   s2_y;
  logic [P1_W-1:0]  s2_p1;
  logic [A_W-1:0]   s2_amag;
  logic             s2_aneg;
  logic [44:0]      s2_p2;
  logic [Y_W-1:0]   y;

  logic [TQ_W-1:0]  s3_tq;
  logic [Q_W-1:0]   s3_q;
  logic [TQ_W-1:0]  eq0;
  logic [Y_W-1:0]   er;
  logic [17:0]      db0;
  logic [A_W-1:0]   dr;
  logic [17:0]      db;
  logic [16:0]      base;

  gain_t            s4_i;
  gain_t            s4_f;
  logic [29:0]      s4_p3;
  logic [Q_W-1:0]   s4_q;
  logic [TI_W-1:0]  ti;

  gain_t            s5_g;
  logic [CV_W-1:0]  s5_vd;
  logic [11:0]      vd0;
  logic [Q_W-1:0]   vr;

  logic [26:0]      s6_w;
  logic [CV_W-1:0]  s6_vd;

  logic [CV_W-1:0]  s7_v;
  logic [CV_W-1:0]  ve;
  logic [8:0]       m;
  logic [CV_W-1:0]  v1;
  logic signed [20:0] t;

  logic [N_W-1:0]   s8_num;
  logic [CV_W-1:0]  s8_lim;
  logic             s8_lower;
  logic [8:0]       bcoef;

  logic [27:0]      s9_p;
  logic [N_W-1:0]   s9_num;
  logic [CV_W-1:0]  s9_lim;
  logic             s9_lower;

  logic [CV_W-1:0]  s10_v;
  logic [9:0]       bq0;
  logic [N_W-1:0]   br;
  logic [8:0]       bq;

  logic [R_W-1:0]   s11_prod;
  logic             s11_neg;
  logic signed [16:0] diff;
  logic [15:0]      dm;

  logic [42:0]      s12_p;
  logic [R_W-1:0]   s12_prod;
  logic             s12_neg;

  logic [16:0]      pq0;
  logic [R_W-1:0]   pr;
  logic [15:0]      pq;
  logic signed [17:0] pv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[NSTG-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    c[0] <= in_ctx;
    for (int k = 1; k < NSTG; k++) begin
      c[k] <= c[k-1];
    end
  end

  // s1: expo exponent product, dual-rate numerator
  always_comb begin
    coef = (c[0].d == 7'd0) ? 17'd100 : ({c[0].d, 10'd0} - 17'd100);
  end

  always_ff @(posedge clk) begin
    s1_x    <= X_W'(c[0].e) * X_W'(10'd1023 - c[0].n);
    s1_amag <= A_W'(c[0].v) * A_W'(coef);
    s1_aneg <= (c[0].d == 7'd0);
  end

  // s2: reciprocal products
  assign y = {s1_x, {EXP_TABLE_BITS{1'b0}}} + Y_W'(EXP_HALF);

  always_ff @(posedge clk) begin
    s2_y    <= y;
    s2_p1   <= P1_W'(y) * P1_W'(M_EXP);
    s2_amag <= s1_amag;
    s2_aneg <= s1_aneg;
    s2_p2   <= 45'(s1_amag) * 45'(M_D1023);
  end

  // s3: quotient correction
  always_comb begin
    eq0  = s2_p1[P1_W-1:Y_W];
    er   = s2_y - Y_W'(eq0) * Y_W'(EXP_DIV);
    db0  = s2_p2[44:A_W];
    dr   = s2_amag - A_W'(db0) * A_W'(1023);
    db   = db0 + 18'(dr >= A_W'(1023));
    base = 17'd51200 - 17'({c[2].d, 9'd0});
  end

  always_ff @(posedge clk) begin
    s3_tq <= eq0 + TQ_W'(er >= Y_W'(EXP_DIV));
    s3_q  <= s2_aneg ? (Q_W'(base) - db) : (Q_W'(base) + db);
  end

  // s4: exp tables
  assign ti = s3_tq[TQ_W-1:EXP_TABLE_BITS];

  always_ff @(posedge clk) begin
    s4_i  <= (ti < TI_W'(12)) ? EXP_INT[ti[3:0]] : '0;
    s4_f  <= FRAC_ROM[s3_tq[EXP_TABLE_BITS-1:0]];
    s4_p3 <= 30'(s3_q) * 30'(M_D100);
    s4_q  <= s3_q;
  end

  // s5: gain, dual-rate result
  always_comb begin
    vd0 = s4_p3[29:Q_W];
    vr  = s4_q - Q_W'(vd0) * Q_W'(100);
  end

  always_ff @(posedge clk) begin
    s5_g  <= 17'((34'(s4_i) * 34'(s4_f) + 34'd32768) >> 16);
    s5_vd <= CV_W'(vd0 + 12'(vr >= Q_W'(100)));
  end

  // s6: apply gain
  always_ff @(posedge clk) begin
    s6_w  <= 27'(c[5].n) * 27'(s5_g);
    s6_vd <= s5_vd;
  end

  // s7: curve select and subtrim
  always_comb begin
    m  = 9'(s6_w >> 17);
    ve = c[6].thr ? CV_W'(s6_w >> 16)
                  : (c[6].neg ? (10'd512 - 10'(m)) : (10'd512 + 10'(m)));
    if (c[6].e != 8'd0) begin
      v1 = ve;
    end else if (c[6].d != 7'd100) begin
      v1 = s6_vd;
    end else begin
      v1 = c[6].v;
    end
    t = $signed({11'b0, v1}) + 21'(c[6].trim) * 21'sd10;
  end

  always_ff @(posedge clk) begin
    if (t < 21'sd0) begin
      s7_v <= '0;
    end else if (t > 21'sd1023) begin
      s7_v <= 10'd1023;
    end else begin
      s7_v <= t[9:0];
    end
  end

  // s8: endpoint products and clamp
  always_comb begin
    bcoef = ~s7_v[9] ? (9'd511 - c[7].lo) : 9'(c[7].hi - 10'd512);
  end

  always_ff @(posedge clk) begin
    s8_lower <= ~s7_v[9];
    s8_num   <= N_W'(s7_v[8:0]) * N_W'(bcoef);
    if (s7_v < 10'(c[7].lo)) begin
      s8_lim <= 10'(c[7].lo);
    end else if (s7_v > c[7].hi) begin
      s8_lim <= c[7].hi;
    end else begin
      s8_lim <= s7_v;
    end
  end

  // s9: divide by 511, product
  always_ff @(posedge clk) begin
    s9_p     <= 28'(s8_num) * 28'(M_D511);
    s9_num   <= s8_num;
    s9_lim   <= s8_lim;
    s9_lower <= s8_lower;
  end

  // s10: bilinear result
  always_comb begin
    bq0 = s9_p[27:N_W];
    br  = s9_num - N_W'(bq0) * N_W'(511);
    bq  = 9'(bq0 + 10'(br >= N_W'(511)));
  end

  always_ff @(posedge clk) begin
    if (c[9].bil) begin
      s10_v <= s9_lower ? (10'(bq) + 10'(c[9].lo)) : (10'(bq) + 10'd512);
    end else begin
      s10_v <= s9_lim;
    end
  end

  // s11: pulse span product
  always_comb begin
    diff = $signed({1'b0, c[10].high}) - $signed({1'b0, c[10].low});
    dm   = (diff < 17'sd0) ? 16'(-diff) : 16'(diff);
  end

  always_ff @(posedge clk) begin
    s11_prod <= R_W'(s10_v) * R_W'(dm);
    s11_neg  <= (diff < 17'sd0);
  end

  // s12: divide by 1023, product
  always_ff @(posedge clk) begin
    s12_p    <= 43'(s11_prod) * 43'(M_R1023);
    s12_prod <= s11_prod;
    s12_neg  <= s11_neg;
  end

  // s13: offset and saturate
  always_comb begin
    pq0 = s12_p[42:R_W];
    pr  = s12_prod - R_W'(pq0) * R_W'(1023);
    pq  = 16'(pq0 + 17'(pr >= R_W'(1023)));
    pv  = s12_neg ? ($signed({2'b0, c[12].low}) - $signed({2'b0, pq}))
                  : ($signed({2'b0, c[12].low}) + $signed({2'b0, pq}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[NSTG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!c[12].ok || (pv < 18'sd0)) begin
      pulse_width <= '0;
    end else if (pv > 18'sd4095) begin
      pulse_width <= 12'd4095;
    end else begin
      pulse_width <= pv[PW_W-1:0];
    end
  end

endmodule

>>> design/rc_channel_pulse_shaper_core.sv
// rc_channel_pulse_shaper_core: top level, config registers, front, queue and back
// depends on rcps_pkg, rcps_front, rcps_queue, rcps_back
//
//   channel   | signals                                            | handshake
//   ----------+----------------------------------------------------+------------------
//   item in   | op channel control_value throttle_cut              | start & !busy
//             | setting_index setting_value                        |
//   result    | pulse_width                                        | done, one cycle
//   config    | cfg_index cfg_data                                 | cfg_we
//
// one item per cycle; a pulse item's result reaches the ports through the front
// register, the queue, 13 back stages and the output register; a write item gives none
// the setting banks are written at the accepting edge and seen by the next item
// rst is synchronous; it clears the config registers and all valid state
// busy only rises if the queue fills, which cannot happen since the back never stalls
module rc_channel_pulse_shaper_core
  import rcps_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic                    op,
  input  logic [CH_W-1:0]         channel,
  input  logic [CV_W-1:0]         control_value,
  input  logic                    throttle_cut,
  input  logic [IDX_W-1:0]        setting_index,
  input  logic signed [SET_W-1:0] setting_value,
  output logic                    done,
  output logic [PW_W-1:0]         pulse_width,
  input  logic                    cfg_we,
  input  logic                    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data
);

  logic [CFG_W-1:0] throttle_channel;
  logic             endpoint_mode;
  logic             q_full;
  logic             push;
  ctx_t             push_ctx;
  logic             pop;
  ctx_t             pop_ctx;

  always_ff @(posedge clk) begin
    if (rst) begin
      throttle_channel <= '0;
      endpoint_mode    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_THROTTLE: throttle_channel <= cfg_data;
        CFG_ENDPOINT: endpoint_mode    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  rcps_front u_front (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .op               (op),
    .channel          (channel),
    .control_value    (control_value),
    .throttle_cut     (throttle_cut),
    .setting_index    (setting_index),
    .setting_value    (setting_value),
    .throttle_channel (throttle_channel),
    .endpoint_mode    (endpoint_mode),
    .q_full           (q_full),
    .push             (push),
    .push_ctx         (push_ctx)
  );

  rcps_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_ctx (push_ctx),
    .full     (q_full),
    .pop      (pop),
    .pop_ctx  (pop_ctx)
  );

  rcps_back u_back (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (pop),
    .in_ctx      (pop_ctx),
    .done        (done),
    .pulse_width (pulse_width)
  );

endmodule

>>> sim/rcps_checker.sv
// rcps_checker: watches the item, config and result ports of the pulse shaper,
// predicts each pulse width from its own copy of the settings and compares in order
// depends on rcps_pkg
module rcps_checker
  import rcps_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic                    busy,
  input  logic                    op,
  input  logic [CH_W-1:0]         channel,
  input  logic [CV_W-1:0]         control_value,
  input  logic                    throttle_cut,
  input  logic [IDX_W-1:0]        setting_index,
  input  logic signed [SET_W-1:0] setting_value,
  input  logic                    done,
  input  logic [PW_W-1:0]         pulse_width,
  input  logic                    cfg_we,
  input  logic                    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  output int                      errors,
  output int                      pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [15:0]     settings [NUM_CHANNELS*NSET];
  logic [3:0]      thr_channel;
  logic            bilinear;
  logic [PW_W-1:0] expected_widths [$];
  longint          exp_frac [FRAC_SIZE];
  longint          exp_whole [12] = '{65536, 24109, 8869, 3263, 1200, 442,
                                      162, 60, 22, 8, 3, 1};

  initial begin
    bit [63:0] f, term, sum;
    errors = 0;
    for (int i = 0; i < FRAC_SIZE; i++) begin
      f    = 64'(i) << (32 - EXP_TABLE_BITS);
      term = 64'd1 << 32;
      sum  = term;
      for (int k = 1; k < 40 && term != 0; k++) begin
        term = ((term * f) >> 32) / 64'(k);
        sum += term;
      end
      exp_frac[i] = longint'(((64'd1 << 48) + sum / 2) / sum);
    end
  end

  assign pending = expected_widths.size();

  function automatic longint sat100(longint x);
    return x > 100 ? 100 : x;
  endfunction

  function automatic longint expo_gain(longint e, longint n);
    longint tq, ti, fi;
    tq = ((e * (1023 - n)) * FRAC_SIZE + EXP_HALF) / EXP_DIV;
    ti = tq >> EXP_TABLE_BITS;
    fi = tq & (FRAC_SIZE - 1);
    if (ti >= 12) return 0;
    return (exp_whole[ti] * exp_frac[fi] + 32768) >> 16;
  endfunction

  function automatic logic [PW_W-1:0] predict_pulse_width(int ch, longint v, bit cut);
    bit     is_thr;
    longint e, d, q, s, m, trim, epl, eph, lo, hi, low, high, t, p;
    is_thr = thr_channel != 0 && ch == int'(thr_channel) - 1;
    e = settings[ch*NSET + SET_EXPO] & 8'hff;
    if (cut && is_thr) v = 0;
    if (e != 0) begin
      if (is_thr) begin
        v = (v * expo_gain(e, v)) >> 16;
      end else begin
        s = 2 * v - 1023;
        m = s < 0 ? -s : s;
        m = (m * expo_gain(e, m)) >> 17;
        v = s < 0 ? 512 - m : 512 + m;
      end
    end else begin
      d = sat100(settings[ch*NSET + SET_DUAL]);
      if (d != 100) begin
        q = (v * (1024 * d - 100)) / 1023 + 51200 - 512 * d;
        v = q / 100;
      end
    end
    trim = longint'($signed(settings[ch*NSET + SET_SUB]));
    if (trim != 0) begin
      s = v + 10 * trim;
      v = s < 0 ? 0 : (s > 1023 ? 1023 : s);
    end
    epl = sat100(settings[ch*NSET + SET_EPL]);
    eph = sat100(settings[ch*NSET + SET_EPH]);
    lo  = (511 * (100 - epl)) / 100;
    if (!bilinear) begin
      hi = 511 + (512 * eph) / 100;
      if (v < lo) v = lo;
      else if (v > hi) v = hi;
    end else if (v < 512) begin
      v = v * (511 - lo) / 511 + lo;
    end else begin
      hi = 512 + (512 * eph) / 100;
      if (hi == 1024) hi = 1023;
      v = (v - 512) * (hi - 512) / 511 + 512;
    end
    low  = settings[ch*NSET + SET_PWL];
    high = settings[ch*NSET + SET_PWH];
    if (settings[ch*NSET + SET_REV] != 0) begin
      t = low; low = high; high = t;
    end
    p = (v * (high - low)) / 1023 + low;
    if (p < 0) p = 0;
    if (p > 4095) p = 4095;
    return PW_W'(p);
  endfunction

  task automatic report(string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      thr_channel <= '0;
      bilinear    <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_THROTTLE) thr_channel <= cfg_data;
        else bilinear <= cfg_data[0];
      end
      if (start && !busy) begin
        if (op == OP_WRITE) settings[channel*NSET + setting_index] = setting_value;
        else expected_widths.push_back(predict_pulse_width(channel, control_value,
                                                           throttle_cut));
      end
      if (done) begin
        if (expected_widths.size() == 0) report($sformatf("unexpected word %0d", pulse_width));
        else if (pulse_width !== expected_widths[0])
          report($sformatf("pulse_width %0d, expected %0d", pulse_width, expected_widths[0]));
        if (expected_widths.size() != 0) void'(expected_widths.pop_front());
      end
    end
  end
endmodule

>>> sim/testbench.sv
// testbench: drives items and config writes into the pulse shaper under varying idle
// rates and gives the verdict; checking is done by rcps_checker
// depends on rcps_pkg, rc_channel_pulse_shaper_core, rcps_checker
module testbench;
  import rcps_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                    clk = 0, rst = 1, start = 0, op = 0, throttle_cut = 0;
  logic [CH_W-1:0]         channel = 0;
  logic [CV_W-1:0]         control_value = 0;
  logic [IDX_W-1:0]        setting_index = 0;
  logic signed [SET_W-1:0] setting_value = 0;
  logic                    cfg_we = 0, cfg_index = 0;
  logic [CFG_W-1:0]        cfg_data = 0;
  logic                    busy, done;
  logic [PW_W-1:0]         pulse_width;
  int                      errors, pending, idle_pct;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  rc_channel_pulse_shaper_core uut (.*);
  rcps_checker checker_i (.*);

  task automatic send(op_t o, int ch, int cv, bit cut, set_idx_t idx, logic [15:0] val);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1; op <= o; channel <= CH_W'(ch); control_value <= CV_W'(cv);
    throttle_cut <= cut;
    setting_index <= idx; setting_value <= val;
    while (busy) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_cfg(cfg_idx_t idx, int val);
    drain();
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= CFG_W'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] rand_setting(set_idx_t idx);
    if ($urandom_range(9) == 0) return 16'($urandom);
    case (idx)
      SET_EXPO: return $urandom_range(2) == 0 ? 16'd0 : 16'($urandom_range(255));
      SET_DUAL, SET_EPL, SET_EPH: return 16'($urandom_range(120));
      SET_SUB: return 16'($signed($urandom_range(40)) - 20);
      SET_PWL, SET_PWH: return 16'($urandom_range(2400, 600));
      default: return 16'($urandom_range(1));
    endcase
  endfunction

  function automatic int rand_cv();
    case ($urandom_range(7))
      0: return 0;
      1: return 1023;
      2: return $urandom_range(520, 504);
      default: return $urandom_range(1023);
    endcase
  endfunction

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int pcts[4] = '{0, 66, 0, 9};
    int thr_vals[4] = '{0, 1, 8, 5};
    set_idx_t si;
    idle_pct = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
      send(OP_WRITE, ch, 0, 0, SET_EXPO, 0);
      send(OP_WRITE, ch, 0, 0, SET_DUAL, 100);
      send(OP_WRITE, ch, 0, 0, SET_SUB, 0);
      send(OP_WRITE, ch, 0, 0, SET_EPL, 100);
      send(OP_WRITE, ch, 0, 0, SET_EPH, 100);
      send(OP_WRITE, ch, 0, 0, SET_PWL, 1000);
      send(OP_WRITE, ch, 0, 0, SET_PWH, 2000);
      send(OP_WRITE, ch, 0, 0, SET_REV, 0);
    end
    write_cfg(CFG_THROTTLE, 1);
    // directed corners
    send(OP_PULSE, 0, 0, 0, SET_EXPO, 0);
    send(OP_PULSE, 0, 1023, 1, SET_EXPO, 0);
    send(OP_WRITE, 0, 0, 0, SET_EXPO, 16'hff80);
    send(OP_PULSE, 0, 1023, 0, SET_EXPO, 0);
    send(OP_PULSE, 0, 700, 0, SET_EXPO, 0);
    send(OP_WRITE, 1, 0, 0, SET_EXPO, 16'h7fff);
    send(OP_PULSE, 1, 0, 0, SET_EXPO, 0);
    send(OP_PULSE, 1, 511, 0, SET_EXPO, 0);
    send(OP_PULSE, 1, 1023, 1, SET_EXPO, 0);
    send(OP_WRITE, 2, 0, 0, SET_DUAL, 16'hffff);
    send(OP_PULSE, 2, 300, 0, SET_EXPO, 0);
    send(OP_WRITE, 2, 0, 0, SET_DUAL, 0);
    send(OP_PULSE, 2, 1023, 0, SET_EXPO, 0);
    send(OP_WRITE, 3, 0, 0, SET_SUB, 16'h7fff);
    send(OP_PULSE, 3, 0, 0, SET_EXPO, 0);
    send(OP_WRITE, 3, 0, 0, SET_SUB, 16'h8000);
    send(OP_PULSE, 3, 1023, 0, SET_EXPO, 0);
    send(OP_WRITE, 4, 0, 0, SET_EPL, 16'd500);
    send(OP_WRITE, 4, 0, 0, SET_EPH, 16'd0);
    send(OP_PULSE, 4, 1023, 0, SET_EXPO, 0);
    send(OP_WRITE, 5, 0, 0, SET_PWH, 16'hffff);
    send(OP_WRITE, 5, 0, 0, SET_REV, 16'h8000);
    send(OP_PULSE, 5, 1023, 0, SET_EXPO, 0);
    send(OP_PULSE, 5, 0, 0, SET_EXPO, 0);
    for (int ph = 0; ph < 4; ph++) begin
      write_cfg(CFG_THROTTLE, thr_vals[ph]);
      write_cfg(CFG_ENDPOINT, ph & 1);
      idle_pct = pcts[ph];
      for (int n = 0; n < 120; n++) begin
        if (n == 60) drain();
        if ($urandom_range(4) == 0) begin
          si = set_idx_t'($urandom_range(7));
          send(OP_WRITE, $urandom_range(7), $urandom, 1'($urandom), si, rand_setting(si));
        end else begin
          send(OP_PULSE, $urandom_range(7), rand_cv(), 1'($urandom), set_idx_t'($urandom),
               16'($urandom));
        end
      end
    end
    drain();
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
